// ----- hw/rtl/sal_pkg.sv -----
// ---------------------------------------------------------------------------
// sal_pkg
// Shared codes, control word layout and microcode table of the sorted
// linked-list block.
// ---------------------------------------------------------------------------
package sal_pkg;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_DELETE = 2'd1;
  localparam logic [1:0] FN_SEARCH = 2'd2;
  localparam logic [1:0] FN_NONE   = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] upc_t;

  typedef enum logic [3:0] {
    A_NOP,
    A_BEGIN,
    A_STEP,
    A_INS_TAKE,
    A_INS_POP,
    A_INS_LINK,
    A_INS_FIX,
    A_DEL_UNLINK,
    A_DEL_PUSH,
    A_SET_FOUND,
    A_SET_DUP,
    A_SET_FULL,
    A_SET_MISS,
    A_FINISH
  } act_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_BADFUNC,
    C_FULL,
    C_WALK,
    C_SEARCH,
    C_DELETE,
    C_FOUND,
    C_NOTFOUND
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
  } ctrl_t;

  typedef struct packed {
    logic badfunc;
    logic full;
    logic walk;
    logic srch;
    logic del;
    logic found;
  } flags_t;

  localparam upc_t L_WALK = upc_t'(3);
  localparam upc_t L_DEL  = upc_t'(11);
  localparam upc_t L_SRCH = upc_t'(14);
  localparam upc_t L_DUP  = upc_t'(16);
  localparam upc_t L_FULL = upc_t'(17);
  localparam upc_t L_MISS = upc_t'(18);
  localparam upc_t L_DONE = upc_t'(19);

  function automatic ctrl_t ucode(upc_t pc);
    ctrl_t w;
    w = '{act: A_NOP, cond: C_ALWAYS, target: L_MISS};
    case (pc)
      upc_t'(0):  w = '{act: A_NOP,        cond: C_BADFUNC,  target: L_MISS};
      upc_t'(1):  w = '{act: A_NOP,        cond: C_FULL,     target: L_FULL};
      upc_t'(2):  w = '{act: A_BEGIN,      cond: C_NEXT,     target: L_WALK};
      upc_t'(3):  w = '{act: A_STEP,       cond: C_WALK,     target: L_WALK};
      upc_t'(4):  w = '{act: A_NOP,        cond: C_SEARCH,   target: L_SRCH};
      upc_t'(5):  w = '{act: A_NOP,        cond: C_DELETE,   target: L_DEL};
      upc_t'(6):  w = '{act: A_NOP,        cond: C_FOUND,    target: L_DUP};
      upc_t'(7):  w = '{act: A_INS_TAKE,   cond: C_NEXT,     target: L_DONE};
      upc_t'(8):  w = '{act: A_INS_POP,    cond: C_NEXT,     target: L_DONE};
      upc_t'(9):  w = '{act: A_INS_LINK,   cond: C_NEXT,     target: L_DONE};
      upc_t'(10): w = '{act: A_INS_FIX,    cond: C_ALWAYS,   target: L_DONE};
      upc_t'(11): w = '{act: A_NOP,        cond: C_NOTFOUND, target: L_MISS};
      upc_t'(12): w = '{act: A_DEL_UNLINK, cond: C_NEXT,     target: L_DONE};
      upc_t'(13): w = '{act: A_DEL_PUSH,   cond: C_ALWAYS,   target: L_DONE};
      upc_t'(14): w = '{act: A_NOP,        cond: C_NOTFOUND, target: L_MISS};
      upc_t'(15): w = '{act: A_SET_FOUND,  cond: C_ALWAYS,   target: L_DONE};
      upc_t'(16): w = '{act: A_SET_DUP,    cond: C_ALWAYS,   target: L_DONE};
      upc_t'(17): w = '{act: A_SET_FULL,   cond: C_ALWAYS,   target: L_DONE};
      upc_t'(18): w = '{act: A_SET_MISS,   cond: C_NEXT,     target: L_DONE};
      upc_t'(19): w = '{act: A_FINISH,     cond: C_NEXT,     target: L_DONE};
      default:    w = '{act: A_NOP,        cond: C_ALWAYS,   target: L_MISS};
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/sorted_array_linked_list.sv -----
// ---------------------------------------------------------------------------
// sorted_array_linked_list
// Sorted key list in a slot store with a free list, run by a microcoded
// sequencer over a key RAM and a link RAM.
// ---------------------------------------------------------------------------
// the walk passes at most SLOTS keys, with one link RAM read per step
// throughput: one word at a time; the next start is taken in the done cycle
// reset: idle after rst; untouched links read as i+1 through a fill mark, so
//   there is no clearing pass
// the done strobe lasts one cycle and cannot be held off
module sorted_array_linked_list #(
  parameter int SLOTS = 64,
  localparam int IW = $clog2(SLOTS),
  localparam int LW = $clog2(SLOTS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         func,
  input  logic signed [31:0] key,
  output logic               busy,
  output logic               done,
  output logic [1:0]         status,
  output logic [IW-1:0]      slot,
  output logic [LW-1:0]      count
);

  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  sal_pkg::ctrl_t  ctrl;
  sal_pkg::flags_t flags;

  logic               busy_next;
  logic               done_next;
  logic [1:0]         func_q;
  logic signed [31:0] key_q;
  logic [LW-1:0]      cur, cur_next;
  logic [LW-1:0]      prev, prev_next;
  logic [LW-1:0]      steps, steps_next;
  logic [IW-1:0]      n_slot, n_slot_next;
  logic [LW-1:0]      list_head, list_head_next;
  logic [LW-1:0]      free_head, free_head_next;
  logic [LW-1:0]      cnt, cnt_next;
  logic [LW-1:0]      hw, hw_next;
  logic [1:0]         status_q, status_next;
  logic [IW-1:0]      slot_q, slot_next;
  logic [IW-1:0]      rd_addr, rd_addr_q;

  logic               key_we;
  logic [IW-1:0]      key_wa;
  logic [31:0]        key_rd;
  logic               link_we;
  logic [IW-1:0]      link_wa;
  logic [LW-1:0]      link_wd;
  logic [LW-1:0]      link_rd;
  logic [LW-1:0]      link_eff;
  logic [LW-1:0]      rd_ext;
  logic               prev_nil;
  logic               live;

  sal_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .run   (busy),
    .flags (flags),
    .ctrl  (ctrl)
  );

  sal_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_wa),
    .wdata (key_q),
    .raddr (rd_addr),
    .rdata (key_rd)
  );

  sal_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_wa),
    .wdata (link_wd),
    .raddr (rd_addr),
    .rdata (link_rd)
  );

  // slots at or above the fill mark were never linked by hand
  assign rd_ext   = LW'(rd_addr_q);
  assign link_eff = (rd_ext >= hw) ? rd_ext + LW'(1) : link_rd;
  assign prev_nil = prev >= NIL;
  assign live     = (cur < NIL) && (steps < NIL);

  always_comb begin
    flags.badfunc = func_q == sal_pkg::FN_NONE;
    flags.full    = (func_q == sal_pkg::FN_INSERT) && (free_head >= NIL);
    flags.walk    = live && ($signed(key_rd) < key_q);
    flags.srch    = func_q == sal_pkg::FN_SEARCH;
    flags.del     = func_q == sal_pkg::FN_DELETE;
    flags.found   = live && ($signed(key_rd) == key_q);
  end

  always_comb begin
    busy_next      = busy;
    done_next      = 1'b0;
    cur_next       = cur;
    prev_next      = prev;
    steps_next     = steps;
    n_slot_next    = n_slot;
    list_head_next = list_head;
    free_head_next = free_head;
    cnt_next       = cnt;
    hw_next        = hw;
    status_next    = status_q;
    slot_next      = slot_q;
    rd_addr        = cur[IW-1:0];
    key_we         = 1'b0;
    key_wa         = free_head[IW-1:0];
    link_we        = 1'b0;
    link_wa        = n_slot;
    link_wd        = link_eff;

    if (start && !busy) begin
      busy_next = 1'b1;
    end

    case (ctrl.act)
      sal_pkg::A_BEGIN: begin
        cur_next   = list_head;
        prev_next  = NIL;
        steps_next = '0;
        rd_addr    = list_head[IW-1:0];
      end
      sal_pkg::A_STEP: begin
        if (flags.walk) begin
          prev_next  = cur;
          cur_next   = link_eff;
          steps_next = steps + LW'(1);
          rd_addr    = link_eff[IW-1:0];
        end
      end
      sal_pkg::A_INS_TAKE: begin
        n_slot_next = free_head[IW-1:0];
        rd_addr     = free_head[IW-1:0];
        key_we      = 1'b1;
      end
      sal_pkg::A_INS_POP: begin
        free_head_next = link_eff;
        rd_addr        = prev[IW-1:0];
      end
      sal_pkg::A_INS_LINK: begin
        link_we = 1'b1;
        link_wa = n_slot;
        if (prev_nil) begin
          link_wd        = list_head;
          list_head_next = LW'(n_slot);
        end
        if (LW'(n_slot) >= hw) begin
          hw_next = LW'(n_slot) + LW'(1);
        end
      end
      sal_pkg::A_INS_FIX: begin
        if (!prev_nil) begin
          link_we = 1'b1;
          link_wa = prev[IW-1:0];
          link_wd = LW'(n_slot);
        end
        if (cnt < NIL) begin
          cnt_next = cnt + LW'(1);
        end
        status_next = sal_pkg::ST_OK;
        slot_next   = n_slot;
      end
      sal_pkg::A_DEL_UNLINK: begin
        if (prev_nil) begin
          list_head_next = link_eff;
        end else begin
          link_we = 1'b1;
          link_wa = prev[IW-1:0];
        end
      end
      sal_pkg::A_DEL_PUSH: begin
        link_we        = 1'b1;
        link_wa        = cur[IW-1:0];
        link_wd        = free_head;
        free_head_next = cur;
        if (cnt != '0) begin
          cnt_next = cnt - LW'(1);
        end
        status_next = sal_pkg::ST_OK;
        slot_next   = cur[IW-1:0];
      end
      sal_pkg::A_SET_FOUND: begin
        status_next = sal_pkg::ST_OK;
        slot_next   = cur[IW-1:0];
      end
      sal_pkg::A_SET_DUP: begin
        status_next = sal_pkg::ST_DUP;
        slot_next   = '0;
      end
      sal_pkg::A_SET_FULL: begin
        status_next = sal_pkg::ST_FULL;
        slot_next   = '0;
      end
      sal_pkg::A_SET_MISS: begin
        status_next = sal_pkg::ST_MISS;
        slot_next   = '0;
      end
      sal_pkg::A_FINISH: begin
        busy_next = 1'b0;
        done_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      done      <= 1'b0;
      list_head <= NIL;
      free_head <= '0;
      cnt       <= '0;
      hw        <= '0;
    end else begin
      busy      <= busy_next;
      done      <= done_next;
      list_head <= list_head_next;
      free_head <= free_head_next;
      cnt       <= cnt_next;
      hw        <= hw_next;
    end
    if (start && !busy) begin
      func_q <= func;
      key_q  <= key;
    end
    cur       <= cur_next;
    prev      <= prev_next;
    steps     <= steps_next;
    n_slot    <= n_slot_next;
    status_q  <= status_next;
    slot_q    <= slot_next;
    rd_addr_q <= rd_addr;
  end

  assign status = status_q;
  assign slot   = slot_q;
  assign count  = cnt;

endmodule

// ----- hw/rtl/sal_ram.sv -----
// ---------------------------------------------------------------------------
// sal_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/sal_seq.sv -----
// ---------------------------------------------------------------------------
// sal_seq
// Micro-sequencer: step counter, control word table and jump conditions.
// ---------------------------------------------------------------------------
module sal_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           run,
  input  sal_pkg::flags_t flags,
  output sal_pkg::ctrl_t  ctrl
);

  sal_pkg::upc_t pc;
  sal_pkg::upc_t pc_next;
  logic          hit;

  always_comb begin
    if (run) begin
      ctrl = sal_pkg::ucode(pc);
    end else begin
      ctrl = '{act: sal_pkg::A_NOP, cond: sal_pkg::C_NEXT, target: sal_pkg::L_DONE};
    end
  end

  always_comb begin
    case (ctrl.cond)
      sal_pkg::C_NEXT:     hit = 1'b0;
      sal_pkg::C_ALWAYS:   hit = 1'b1;
      sal_pkg::C_BADFUNC:  hit = flags.badfunc;
      sal_pkg::C_FULL:     hit = flags.full;
      sal_pkg::C_WALK:     hit = flags.walk;
      sal_pkg::C_SEARCH:   hit = flags.srch;
      sal_pkg::C_DELETE:   hit = flags.del;
      sal_pkg::C_FOUND:    hit = flags.found;
      sal_pkg::C_NOTFOUND: hit = !flags.found;
      default:             hit = 1'b0;
    endcase
  end

  always_comb begin
    if (!run || ctrl.act == sal_pkg::A_FINISH) begin
      pc_next = '0;
    end else if (hit) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + sal_pkg::upc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ----- hw/rtl/sal_checker.sv -----
// ---------------------------------------------------------------------------
// sal_checker
// Port-level checks of the sorted linked-list block, bound to the top level.
// ---------------------------------------------------------------------------
module sal_checker #(
  parameter int SLOTS = 64,
  localparam int IW = $clog2(SLOTS),
  localparam int LW = $clog2(SLOTS + 1)
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [1:0]         status,
  input logic [IW-1:0]      slot,
  input logic [LW-1:0]      count
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done strobe while busy");

  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("busy fell without a result");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    done |-> (count <= LW'(SLOTS)))
    else $error("count above slot total");

  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    (done && status != sal_pkg::ST_OK) |-> (slot == '0))
    else $error("failed result with nonzero slot");

endmodule

bind sorted_array_linked_list sal_checker #(.SLOTS(SLOTS)) u_sal_checker (.*);
